FILE: src/ep2dt_pkg.sv
// Shared types, constants and control store for the epoch seconds to date converter.
package ep2dt_pkg;

    localparam int unsigned PC_W    = 3;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned DSEL_W  = 2;
    localparam int unsigned K_W     = 4;

    // Program counter values
    localparam logic [PC_W-1:0] PC_WAIT  = 3'd0;
    localparam logic [PC_W-1:0] PC_MOD   = 3'd1;
    localparam logic [PC_W-1:0] PC_DAY   = 3'd2;
    localparam logic [PC_W-1:0] PC_HOUR  = 3'd3;
    localparam logic [PC_W-1:0] PC_MIN   = 3'd4;
    localparam logic [PC_W-1:0] PC_YEAR  = 3'd5;
    localparam logic [PC_W-1:0] PC_MONTH = 3'd6;
    localparam logic [PC_W-1:0] PC_EMIT  = 3'd7;

    // Micro-operations
    localparam logic [OP_W-1:0] OP_WAIT  = 3'd0;
    localparam logic [OP_W-1:0] OP_MOD   = 3'd1;
    localparam logic [OP_W-1:0] OP_DIV   = 3'd2;
    localparam logic [OP_W-1:0] OP_YEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_MONTH = 3'd4;
    localparam logic [OP_W-1:0] OP_EMIT  = 3'd5;

    // Divisor / destination select for the shared divide step
    localparam logic [DSEL_W-1:0] DSEL_DAY  = 2'd0;
    localparam logic [DSEL_W-1:0] DSEL_HOUR = 2'd1;
    localparam logic [DSEL_W-1:0] DSEL_MIN  = 2'd2;
    localparam logic [DSEL_W-1:0] DSEL_NONE = 2'd3;

    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [16:0] SEC_PER_MIN  = 17'd60;

    // Reciprocals for the constant divides: quotient = (x * M) >> S, exact over each range
    localparam logic [25:0] DAY_RECIP    = 26'd50903317; // 2^35 / 675, x = seconds >> 7
    localparam logic [13:0] HOUR_RECIP   = 14'd9321;     // 2^21 / 225, x = seconds >> 4
    localparam logic [10:0] MIN_RECIP    = 11'd1093;     // 2^14 / 15, x = seconds >> 2

    localparam logic [11:0] CYCLE_YEARS  = 12'd400;
    localparam logic [11:0] CENTURY_1    = 12'd100;
    localparam logic [11:0] CENTURY_2    = 12'd200;
    localparam logic [11:0] CENTURY_3    = 12'd300;
    localparam logic [11:0] CYCLE_LAST   = 12'd399;

    localparam logic [8:0]  DAYS_LEAP    = 9'd366;
    localparam logic [8:0]  DAYS_COMMON  = 9'd365;
    localparam logic [4:0]  FEB_LEAP     = 5'd29;
    localparam logic [3:0]  MONTH_FEB    = 4'd1;
    localparam logic [3:0]  MONTH_DEC    = 4'd11;
    localparam logic [11:0] BASE_YEAR_RST = 12'd2000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DSEL_W-1:0] dsel;
        logic [K_W-1:0]    k_top;
        logic [PC_W-1:0]   nxt;
    } t_uword;

    // Control store: one word per step
    function automatic t_uword f_prog(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            PC_WAIT:  w = '{op: OP_WAIT,  dsel: DSEL_NONE, k_top: 4'd0,  nxt: PC_MOD};
            PC_MOD:   w = '{op: OP_MOD,   dsel: DSEL_NONE, k_top: 4'd0,  nxt: PC_DAY};
            PC_DAY:   w = '{op: OP_DIV,   dsel: DSEL_DAY,  k_top: 4'd1,  nxt: PC_HOUR};
            PC_HOUR:  w = '{op: OP_DIV,   dsel: DSEL_HOUR, k_top: 4'd1,  nxt: PC_MIN};
            PC_MIN:   w = '{op: OP_DIV,   dsel: DSEL_MIN,  k_top: 4'd1,  nxt: PC_YEAR};
            PC_YEAR:  w = '{op: OP_YEAR,  dsel: DSEL_NONE, k_top: 4'd0,  nxt: PC_MONTH};
            PC_MONTH: w = '{op: OP_MONTH, dsel: DSEL_NONE, k_top: 4'd0,  nxt: PC_EMIT};
            PC_EMIT:  w = '{op: OP_EMIT,  dsel: DSEL_NONE, k_top: 4'd0,  nxt: PC_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic [16:0] f_divisor(input logic [DSEL_W-1:0] dsel);
        logic [16:0] d;
        unique case (dsel)
            DSEL_DAY:  d = SEC_PER_DAY;
            DSEL_HOUR: d = SEC_PER_HOUR;
            DSEL_MIN:  d = SEC_PER_MIN;
            DSEL_NONE: d = SEC_PER_MIN;
        endcase
        return d;
    endfunction

    // Month lengths for a common year, January is index zero
    function automatic logic [4:0] f_month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1:                    len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: src/epoch_seconds_to_date_time_top.sv
// Top level: microcoded converter from epoch seconds to calendar date and time.
//
// Input channel i_valid / o_ready carries i_total_seconds, seconds since
// midnight January 1 of the base year. Output channel o_valid / i_ready
// carries second, minute, hour, day of month, month and year offset.
// Configuration channel i_cfg_valid / o_cfg_ready writes the 12-bit base
// year; it is always ready and is meant to be written while idle.
// One item is worked at a time by a small control store that steps a
// shared divide step (reciprocal multiply, then remainder), a year loop
// and a month loop.
// The year loop, one year per cycle, dominates the time from accept to
// o_valid. o_ready rises again in the cycle after the result moves to the
// output register.
// A finished result sits in an output register; a stalled receiver stalls
// the sequencer only when a second result is ready to be written there.
// Reset (synchronous, active low) empties the output, returns the
// sequencer to waiting and sets the base year to 2000.
module epoch_seconds_to_date_time_top
    import ep2dt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_total_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_second_of_minute,
    output logic [5:0]  o_minute_of_hour,
    output logic [4:0]  o_hour_of_day,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month_of_year,
    output logic [7:0]  o_year_offset,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data
);

    logic [PC_W-1:0] r_pc, n_pc;
    logic [K_W-1:0]  r_k, n_k;
    logic [31:0]     r_rem, n_rem;
    logic [15:0]     r_q, n_q;
    logic [15:0]     r_days, n_days;
    logic [4:0]      r_hour, n_hour;
    logic [5:0]      r_min, n_min;
    logic [11:0]     r_y400, n_y400;
    logic [7:0]      r_yoff, n_yoff;
    logic [3:0]      r_month, n_month;
    logic [11:0]     r_base_year;
    logic            r_out_valid, n_out_valid;
    logic [5:0]      r_o_sec, r_o_min;
    logic [4:0]      r_o_hour, r_o_day;
    logic [3:0]      r_o_month;
    logic [7:0]      r_o_yoff;
    logic            load_out;

    t_uword          w_word, w_nxt_word;
    logic [50:0]     day_prod;
    logic [26:0]     hour_prod;
    logic [20:0]     min_prod;
    logic [15:0]     recip_q;
    logic [32:0]     q_times_d;
    logic            leap;
    logic [8:0]      ylen;
    logic [4:0]      mlen;
    logic            advance;

    assign w_word     = f_prog(r_pc);
    assign w_nxt_word = f_prog(w_word.nxt);

    // Each divisor is a power of two times an odd part; drop the power first
    assign day_prod   = r_rem[31:7] * DAY_RECIP;
    assign hour_prod  = r_rem[16:4] * HOUR_RECIP;
    assign min_prod   = r_rem[11:2] * MIN_RECIP;
    assign q_times_d  = r_q * f_divisor(w_word.dsel);

    always_comb begin
        unique case (w_word.dsel)
            DSEL_DAY:  recip_q = day_prod[50:35];
            DSEL_HOUR: recip_q = {10'd0, hour_prod[26:21]};
            DSEL_MIN:  recip_q = {9'd0, min_prod[20:14]};
            DSEL_NONE: recip_q = 16'd0;
        endcase
    end

    // 400 is a multiple of 4, so the low bits of the cycle position give year mod 4
    assign leap = (r_y400[1:0] == 2'b00) && (r_y400 != CENTURY_1)
                  && (r_y400 != CENTURY_2) && (r_y400 != CENTURY_3);
    assign ylen = leap ? DAYS_LEAP : DAYS_COMMON;
    assign mlen = (leap && (r_month == MONTH_FEB)) ? FEB_LEAP : f_month_len(r_month);

    assign o_ready     = (w_word.op == OP_WAIT);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_pc        = r_pc;
        n_k         = r_k;
        n_rem       = r_rem;
        n_q         = r_q;
        n_days      = r_days;
        n_hour      = r_hour;
        n_min       = r_min;
        n_y400      = r_y400;
        n_yoff      = r_yoff;
        n_month     = r_month;
        n_out_valid = r_out_valid && !i_ready;
        load_out    = 1'b0;
        advance     = 1'b0;
        unique case (w_word.op)
            OP_WAIT: begin
                if (i_valid) begin
                    n_rem   = i_total_seconds;
                    n_y400  = r_base_year;
                    n_yoff  = 8'd0;
                    n_month = 4'd0;
                    n_q     = 16'd0;
                    advance = 1'b1;
                end
            end
            OP_MOD: begin
                // reduce the base year to its place in the 400-year cycle
                if (r_y400 >= CYCLE_YEARS) begin
                    n_y400 = r_y400 - CYCLE_YEARS;
                end else begin
                    advance = 1'b1;
                end
            end
            OP_DIV: begin
                if (r_k != '0) begin
                    // quotient step: reciprocal multiply
                    n_q = recip_q;
                    n_k = r_k - 4'd1;
                end else begin
                    // remainder step, and store the quotient
                    n_rem   = r_rem - q_times_d[31:0];
                    n_q     = 16'd0;
                    advance = 1'b1;
                    unique case (w_word.dsel)
                        DSEL_DAY:  n_days = r_q;
                        DSEL_HOUR: n_hour = r_q[4:0];
                        DSEL_MIN:  n_min  = r_q[5:0];
                        DSEL_NONE: n_q    = 16'd0;
                    endcase
                end
            end
            OP_YEAR: begin
                if (r_days >= {7'd0, ylen}) begin
                    n_days = r_days - {7'd0, ylen};
                    n_yoff = r_yoff + 8'd1;
                    n_y400 = (r_y400 == CYCLE_LAST) ? 12'd0 : r_y400 + 12'd1;
                end else begin
                    advance = 1'b1;
                end
            end
            OP_MONTH: begin
                if ((r_month != MONTH_DEC) && (r_days >= {11'd0, mlen})) begin
                    n_days  = r_days - {11'd0, mlen};
                    n_month = r_month + 4'd1;
                end else begin
                    advance = 1'b1;
                end
            end
            OP_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    advance     = 1'b1;
                end
            end
            default: begin
                advance = 1'b1;
            end
        endcase
        if (advance) begin
            n_pc = w_word.nxt;
            n_k  = w_nxt_word.k_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_WAIT;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_base_year <= BASE_YEAR_RST;
        end else begin
            r_pc        <= n_pc;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_base_year <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_days  <= n_days;
        r_hour  <= n_hour;
        r_min   <= n_min;
        r_y400  <= n_y400;
        r_yoff  <= n_yoff;
        r_month <= n_month;
        if (load_out) begin
            r_o_sec   <= r_rem[5:0];
            r_o_min   <= r_min;
            r_o_hour  <= r_hour;
            r_o_day   <= r_days[4:0] + 5'd1;
            r_o_month <= r_month + 4'd1;
            r_o_yoff  <= r_yoff;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_second_of_minute = r_o_sec;
    assign o_minute_of_hour   = r_o_min;
    assign o_hour_of_day      = r_o_hour;
    assign o_day_of_month     = r_o_day;
    assign o_month_of_year    = r_o_month;
    assign o_year_offset      = r_o_yoff;

    // Divide steps leave only the seconds of the minute behind
    a_rem_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_YEAR) |-> (r_rem < 32'd60))
        else $error("remainder not reduced below one minute");

    // Cycle position stays reduced once the year loop runs
    a_cycle_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_YEAR || r_pc == PC_MONTH) |-> (r_y400 < CYCLE_YEARS))
        else $error("year cycle position out of range");

    // Month loop never runs past December
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_MONTH || r_pc == PC_EMIT) |-> (r_month <= MONTH_DEC))
        else $error("month index out of range");

    // What remains at emit fits within one month
    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_EMIT) |-> (r_days < 16'd31))
        else $error("day remainder exceeds a month");

    // A result is written to the output only when the register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_EMIT && r_out_valid && !i_ready) |=> (r_pc == PC_EMIT))
        else $error("result dropped while output stalled");

endmodule
